FILE: rtl/rsi_ws_pkg.sv
// ----------------------------------------------------------------------------
// rsi_ws_pkg - shared definitions for the Wilder-smoothed RSI unit
// Defaults, register indexes, fixed-point constants and sequencer states.
// ----------------------------------------------------------------------------
package rsi_ws_pkg;

  localparam int unsigned PRICE_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // config port
  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSS  = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd14;

  // RSI scale: 100 needs seven integer bits
  localparam int unsigned RSI_SCALE    = 100;
  localparam int unsigned RSI_INT_BITS = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_RSI_PREP,
    ST_RSI_DIV,
    ST_DONE
  } st_e;

  // which average the shared divider is producing
  typedef enum logic [1:0] {
    JOB_ST_UP,
    JOB_ST_DN,
    JOB_OUT_UP,
    JOB_OUT_DN
  } job_e;

endpackage

FILE: rtl/rsi_wilder_smoothing_unit.sv
// ----------------------------------------------------------------------------
// rsi_wilder_smoothing_unit - Wilder-smoothed relative strength index
// One close per input beat, one result beat (moves, averages, RSI) per input.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries a primary close, a second
//   series close and a start-of-series flag. Output channel
//   (out_valid_o/out_ready_i) returns up/down move, the two Q32.16 Wilder
//   averages and RSI in Q7.16. Config writes (cfg_we_i) set the period and
//   cross mode; write them only while the unit is idle.
//   Steps: a first-of-series beat goes from accept straight to hand-over.
//   Otherwise each Wilder average is a multiply step plus a bit-serial
//   restoring division by N giving ACC_W = PRICE_BITS+FRAC_BITS+8 quotient
//   bits; two averages are needed (four in cross mode), then a step to set
//   up RSI and a bit-serial RSI division of FRAC_BITS+7 bits (skipped when
//   the down average is zero), then a hand-over step.
//   The sequencer works on one beat at a time.
//   The result sits in an output register, so a new input beat is accepted
//   while the previous result still waits; a stalled receiver only holds
//   the finished next result in the last step.
//   Reset: period 14, cross mode off, no previous close (next beat starts a
//   series), output channel empty.
// ----------------------------------------------------------------------------
module rsi_wilder_smoothing_unit
  import rsi_ws_pkg::*;
#(
  parameter int unsigned PRICE_BITS = PRICE_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config
  input  logic                                cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]               cfg_data_i,
  // input beat
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [PRICE_BITS-1:0]               close_price_i,
  input  logic [PRICE_BITS-1:0]               second_close_i,
  input  logic                                start_of_series_i,
  // result beat
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [FRAC_BITS+RSI_INT_BITS-1:0]   rsi_value_o,
  output logic [PRICE_BITS-1:0]               up_move_o,
  output logic [PRICE_BITS-1:0]               down_move_o,
  output logic [PRICE_BITS+FRAC_BITS-1:0]     avg_up_o,
  output logic [PRICE_BITS+FRAC_BITS-1:0]     avg_down_o
);

  localparam int unsigned AW    = PRICE_BITS + FRAC_BITS;      // average width
  localparam int unsigned ACC_W = AW + PERIOD_W;               // avg*(N-1)+move
  localparam int unsigned RSI_W = FRAC_BITS + RSI_INT_BITS;
  localparam int unsigned X_W   = AW + RSI_INT_BITS;           // 100*avg_up
  localparam int unsigned R_W   = X_W + 1;                     // RSI partial rem
  localparam int unsigned CNT_W = $clog2(ACC_W + 1);

  localparam logic [RSI_W-1:0] RSI_FULL = RSI_W'(RSI_SCALE) << FRAC_BITS;

  // --------------------------------------------------------------------------
  // Control and config state
  // --------------------------------------------------------------------------
  st_e                  state_q, state_d;
  job_e                 job_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 primed_q;
  logic                 out_valid_q;
  logic [PERIOD_W-1:0]  period_q;
  logic                 cross_q;

  // Working registers (payload, no reset)
  logic [PRICE_BITS-1:0] last_close_q;
  logic [AW-1:0]         su_q, sd_q;          // smoothed averages (state)
  logic [PRICE_BITS-1:0] close_q;
  logic [PRICE_BITS-1:0] st_up_q, st_dn_q;    // moves that advance state
  logic [PRICE_BITS-1:0] o_up_q, o_dn_q;      // moves that are reported
  logic [AW-1:0]         nup_q, ndn_q;        // next state averages
  logic [AW-1:0]         oavu_q, oavd_q;      // reported averages
  logic [ACC_W-1:0]      dvd_q;               // dividend in, quotient out
  logic [PERIOD_W-1:0]   rem_q;
  logic [AW:0]           s_q;                 // avg_up + avg_down
  logic [R_W-1:0]        r_q;
  logic [RSI_W-1:0]      rsi_q;

  // Output register
  logic [RSI_W-1:0]      out_rsi_q;
  logic [PRICE_BITS-1:0] out_up_q, out_dn_q;
  logic [AW-1:0]         out_avu_q, out_avd_q;

  // --------------------------------------------------------------------------
  // Move extraction straight off the input beat
  // --------------------------------------------------------------------------
  logic                  first_w;
  logic                  st_gt, o_gt;
  logic [PRICE_BITS-1:0] sel_close;
  logic [PRICE_BITS-1:0] st_up_w, st_dn_w, o_up_w, o_dn_w;

  assign first_w   = start_of_series_i || !primed_q;
  assign st_gt     = close_price_i > last_close_q;
  assign st_up_w   = st_gt ? close_price_i - last_close_q : '0;
  assign st_dn_w   = st_gt ? '0 : last_close_q - close_price_i;
  assign sel_close = cross_q ? second_close_i : close_price_i;
  assign o_gt      = sel_close > last_close_q;
  assign o_up_w    = o_gt ? sel_close - last_close_q : '0;
  assign o_dn_w    = o_gt ? '0 : last_close_q - sel_close;

  // --------------------------------------------------------------------------
  // Wilder step: acc = avg*(N-1) + (move << FRAC), then acc / N bit-serially
  // --------------------------------------------------------------------------
  logic [PERIOD_W-1:0]   n_w, nm1_w;
  logic [AW-1:0]         avg_sel;
  logic [PRICE_BITS-1:0] move_sel;
  logic [ACC_W-1:0]      acc_w;
  logic [PERIOD_W:0]     trial_w;
  logic                  q_bit;
  logic [PERIOD_W:0]     trial_sub;
  logic [ACC_W-1:0]      dvd_d;

  assign n_w   = (period_q == '0) ? PERIOD_W'(1) : period_q;   // period 0 acts as 1
  assign nm1_w = n_w - PERIOD_W'(1);

  always_comb begin
    avg_sel  = su_q;
    move_sel = st_up_q;
    case (job_q)
      JOB_ST_UP: begin
        avg_sel  = su_q;
        move_sel = st_up_q;
      end
      JOB_ST_DN: begin
        avg_sel  = sd_q;
        move_sel = st_dn_q;
      end
      JOB_OUT_UP: begin
        avg_sel  = su_q;
        move_sel = o_up_q;
      end
      JOB_OUT_DN: begin
        avg_sel  = sd_q;
        move_sel = o_dn_q;
      end
      default: begin
        avg_sel  = su_q;
        move_sel = st_up_q;
      end
    endcase
  end

  assign acc_w = (ACC_W'(avg_sel) * ACC_W'(nm1_w)) + (ACC_W'(move_sel) << FRAC_BITS);

  // one quotient bit per cycle; remainder never reaches N
  assign trial_w   = {rem_q, dvd_q[ACC_W-1]};
  assign q_bit     = trial_w >= {1'b0, n_w};
  assign trial_sub = q_bit ? (trial_w - {1'b0, n_w}) : trial_w;
  assign dvd_d     = {dvd_q[ACC_W-2:0], q_bit};

  // --------------------------------------------------------------------------
  // RSI: floor(100 * 2^FRAC * up / (up + down)), one bit per cycle
  // --------------------------------------------------------------------------
  logic [R_W-1:0] rsi_tgt;
  logic           r_bit;
  logic [R_W-1:0] r_sub;

  assign rsi_tgt = R_W'({s_q, (RSI_INT_BITS - 1)'(0)});
  assign r_bit   = r_q >= rsi_tgt;
  assign r_sub   = r_bit ? (r_q - rsi_tgt) : r_q;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic accept;
  logic div_last, rsi_last;
  logic out_load;
  logic last_avg;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign div_last   = (cnt_q == CNT_W'(ACC_W - 1));
  assign rsi_last   = (cnt_q == CNT_W'(RSI_W - 1));
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign last_avg   = (job_q == JOB_OUT_DN) || ((job_q == JOB_ST_DN) && !cross_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = first_w ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_last) begin
          state_d = last_avg ? ST_RSI_PREP : ST_MUL;
        end
      end
      ST_RSI_PREP: begin
        state_d = (oavd_q == '0) ? ST_DONE : ST_RSI_DIV;
      end
      ST_RSI_DIV: begin
        if (rsi_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q       <= JOB_ST_UP;
      cnt_q       <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      period_q    <= PERIOD_RST;
      cross_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
          CFG_CROSS:  cross_q  <= cfg_data_i[0];
          default:    ;
        endcase
      end

      if (accept) begin
        job_q <= JOB_ST_UP;
      end else if ((state_q == ST_DIV) && div_last) begin
        case (job_q)
          JOB_ST_UP:  job_q <= JOB_ST_DN;
          JOB_ST_DN:  job_q <= JOB_OUT_UP;
          JOB_OUT_UP: job_q <= JOB_OUT_DN;
          default:    job_q <= JOB_ST_UP;
        endcase
      end

      if ((state_q == ST_MUL) || (state_q == ST_RSI_PREP)) begin
        cnt_q <= '0;
      end else if ((state_q == ST_DIV) || (state_q == ST_RSI_DIV)) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end

      if (out_load) begin
        primed_q <= 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          close_q <= close_price_i;
          st_up_q <= st_up_w;
          st_dn_q <= st_dn_w;
          if (first_w) begin
            // new series: zero moves and averages, RSI pinned at 100
            o_up_q <= '0;
            o_dn_q <= '0;
            nup_q  <= '0;
            ndn_q  <= '0;
            oavu_q <= '0;
            oavd_q <= '0;
            rsi_q  <= RSI_FULL;
          end else begin
            o_up_q <= o_up_w;
            o_dn_q <= o_dn_w;
          end
        end
      end
      ST_MUL: begin
        dvd_q <= acc_w;
        rem_q <= '0;
      end
      ST_DIV: begin
        dvd_q <= dvd_d;
        rem_q <= trial_sub[PERIOD_W-1:0];
        if (div_last) begin
          case (job_q)
            JOB_ST_UP: begin
              nup_q <= dvd_d[AW-1:0];
              if (!cross_q) begin
                oavu_q <= dvd_d[AW-1:0];
              end
            end
            JOB_ST_DN: begin
              ndn_q <= dvd_d[AW-1:0];
              if (!cross_q) begin
                oavd_q <= dvd_d[AW-1:0];
              end
            end
            JOB_OUT_UP: oavu_q <= dvd_d[AW-1:0];
            JOB_OUT_DN: oavd_q <= dvd_d[AW-1:0];
            default:    ;
          endcase
        end
      end
      ST_RSI_PREP: begin
        s_q <= (AW + 1)'(oavu_q) + (AW + 1)'(oavd_q);
        r_q <= R_W'(oavu_q) * R_W'(RSI_SCALE);
        if (oavd_q == '0) begin
          rsi_q <= RSI_FULL;
        end
      end
      ST_RSI_DIV: begin
        r_q   <= r_sub << 1;
        rsi_q <= {rsi_q[RSI_W-2:0], r_bit};
      end
      ST_DONE: begin
        if (out_load) begin
          last_close_q <= close_q;
          su_q         <= nup_q;
          sd_q         <= ndn_q;
          out_rsi_q    <= rsi_q;
          out_up_q     <= o_up_q;
          out_dn_q     <= o_dn_q;
          out_avu_q    <= oavu_q;
          out_avd_q    <= oavd_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign rsi_value_o = out_rsi_q;
  assign up_move_o   = out_up_q;
  assign down_move_o = out_dn_q;
  assign avg_up_o    = out_avu_q;
  assign avg_down_o  = out_avd_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_div_rem_below_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < n_w))
    else $error("serial divider remainder reached N");

  a_div_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q < CNT_W'(ACC_W)))
    else $error("divider step count overran");

  a_rsi_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RSI_DIV) |-> ((s_q != '0) && (r_q < (rsi_tgt << 1))))
    else $error("RSI partial remainder out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("sequencer stayed idle after an accepted beat");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && (state_q == ST_DONE)) |=> (state_q == ST_DONE))
    else $error("result left the sequencer while the output register was full");

endmodule
